>>> hw/rtl/srb_pkg.sv
// Shared types, codes and constants of the sequence reorder buffer.
// No dependencies; every other file of the block imports this package.
package srb_pkg;

    // Default geometry (WINDOW must be a power of two)
    localparam int STREAMS_DEF = 16;
    localparam int WINDOW_DEF  = 32;

    // Function codes on the input tuser
    localparam logic [1:0] FUNC_PKT  = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_RST  = 2'd2;

    // Result kinds on the output tuser
    localparam logic [1:0] KIND_DELIV = 2'd0;
    localparam logic [1:0] KIND_DROP  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_HOLD   = 1'b1;

    localparam logic [27:0] HOLD_MIN   = 28'd100000;
    localparam logic [27:0] HOLD_MAX   = 28'd200000000;
    localparam logic [27:0] HOLD_RESET = 28'd2000000;
    localparam logic        ENABLE_RESET = 1'b1;

    // Command class decided by the front end
    typedef enum logic [2:0] {
        CLS_PASS,
        CLS_PKT,
        CLS_TICK,
        CLS_RST,
        CLS_NOP
    } cls_t;

    // What follows a flush walk
    typedef enum logic [1:0] {
        FT_NEW,
        FT_RST,
        FT_JUMP
    } fthen_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_FL_RD,
        S_FL_CHK,
        S_GAPCHK,
        S_GS_RD,
        S_GS_CHK,
        S_GS_END,
        S_SEQCHK,
        S_SL_RD,
        S_SL_CHK,
        S_PR_RD,
        S_PR_CHK,
        S_ONE,
        S_FIN
    } st_t;

    typedef struct packed {
        cls_t        cls;
        logic [3:0]  stream_id;
        logic [31:0] epoch;
        logic [31:0] seq;
        logic [31:0] handle;
        logic [47:0] now;
    } cmd_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] seq;
        logic [31:0] handle;
    } slot_t;

endpackage

>>> hw/rtl/srb_front.sv
// Front end: accepts input words, classifies them and queues commands.
// Depends on srb_pkg.
module srb_front #(
    parameter int STREAMS = srb_pkg::STREAMS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enable,
    input  logic          clear_done,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [151:0]  s_tdata,   // stream_id[3:0], epoch, seq, handle, now, zero pad
    input  logic [1:0]    s_tuser,   // func
    output logic          cmd_valid,
    output srb_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import srb_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cin;
    logic       in_range;
    logic       push;

    // Classify the incoming word
    always_comb
    begin
        cin.stream_id = s_tdata[3:0];
        cin.epoch     = s_tdata[35:4];
        cin.seq       = s_tdata[67:36];
        cin.handle    = s_tdata[99:68];
        cin.now       = s_tdata[147:100];
        in_range      = ({28'd0, s_tdata[3:0]} < 32'(STREAMS));
        case (s_tuser)
            FUNC_PKT:  cin.cls = (!enable || !in_range) ? CLS_PASS : CLS_PKT;
            FUNC_TICK: cin.cls = (enable && in_range) ? CLS_TICK : CLS_NOP;
            FUNC_RST:  cin.cls = in_range ? CLS_RST : CLS_NOP;
            default:   cin.cls = CLS_NOP;
        endcase
    end

    assign s_tready  = (cnt_reg != 2'd2) && clear_done;
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cin;
    end

endmodule

>>> hw/rtl/srb_back.sv
// Back end: per-stream state, slot memory and the sequencer that stores,
// drains, flushes and skips gaps; holds the output register. Depends on srb_pkg.
module srb_back #(
    parameter int STREAMS = srb_pkg::STREAMS_DEF,
    parameter int WINDOW  = srb_pkg::WINDOW_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  srb_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic [27:0]   hold_time,
    output logic          clear_done,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,   // out_handle
    output logic [1:0]    m_tuser,   // kind
    output logic          m_tlast
);
    import srb_pkg::*;

    localparam int SIW   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int WW    = $clog2(WINDOW);
    localparam int DEPTH = STREAMS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = $clog2(WINDOW + 1);

    // Per-stream state
    logic              sv_arr  [STREAMS];
    logic [31:0]       ep_arr  [STREAMS];
    logic [31:0]       ne_arr  [STREAMS];
    logic [HW-1:0]     hc_arr  [STREAMS];
    logic [47:0]       gs_arr  [STREAMS];

    // Slot memory
    slot_t             mem [DEPTH];
    slot_t             rd_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    slot_t             wr_data;

    st_t               st_reg, st_next;
    cmd_t              cmd_reg, cmd_next;
    logic [SIW-1:0]    sidx_reg, sidx_next;
    logic              w_valid_reg, w_valid_next;
    logic [31:0]       w_epoch_reg, w_epoch_next;
    logic [31:0]       w_ne_reg, w_ne_next;
    logic [HW-1:0]     w_held_reg, w_held_next;
    logic [47:0]       w_gs_reg, w_gs_next;
    logic [WW-1:0]     i_reg, i_next;
    logic              found_reg, found_next;
    logic [31:0]       best_d_reg, best_d_next;
    logic [31:0]       best_seq_reg, best_seq_next;
    logic              poured_reg, poured_next;
    fthen_t            fthen_reg, fthen_next;
    logic [1:0]        one_kind_reg, one_kind_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [1:0]        pend_kind_reg, pend_kind_next;
    logic [31:0]       pend_handle_reg, pend_handle_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic [31:0]       out_handle_reg, out_handle_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              emit_need;
    logic              stall;
    logic              emit;
    logic [1:0]        emit_kind;
    logic [31:0]       emit_handle;
    logic              wb_en;
    logic              ready;
    logic              gap_due;
    logic              last_slot;
    logic [31:0]       d_seq;
    logic [31:0]       d_slot;
    logic [47:0]       elapsed;

    assign out_free   = !out_valid_reg || m_tready;
    assign clear_done = (st_reg != S_CLEAR);
    assign last_slot  = (i_reg == WW'(WINDOW - 1));
    assign ready      = rd_reg.valid && (rd_reg.seq == w_ne_reg) && w_valid_reg;
    assign elapsed    = cmd_reg.now - w_gs_reg;
    assign gap_due    = (w_held_reg != '0) && (w_gs_reg != '0) &&
                        (elapsed >= {20'd0, hold_time});
    assign d_seq      = cmd_reg.seq - w_ne_reg;
    assign d_slot     = rd_reg.seq - w_ne_reg;

    // A state that emits a result stalls while the pending slot cannot spill
    always_comb
    begin
        case (st_reg)
            S_FL_CHK: emit_need = rd_reg.valid;
            S_PR_CHK: emit_need = ready;
            S_ONE:    emit_need = 1'b1;
            S_FIN:    emit_need = pend_valid_reg;
            default:  emit_need = 1'b0;
        endcase
        stall = emit_need && pend_valid_reg && !out_free;
    end

    // Next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_CLEAR:  if (clr_reg == AW'(DEPTH - 1)) st_next = S_IDLE;
            S_IDLE:   if (cmd_valid) st_next = S_DECIDE;
            S_DECIDE:
            begin
                case (cmd_reg.cls)
                    CLS_PASS: st_next = S_ONE;
                    CLS_RST:  st_next = S_FL_RD;
                    CLS_TICK: st_next = w_valid_reg ? S_GAPCHK : S_FIN;
                    CLS_PKT:  st_next = (!w_valid_reg || w_epoch_reg != cmd_reg.epoch) ?
                                        S_FL_RD : S_GAPCHK;
                    default:  st_next = S_FIN;
                endcase
            end
            S_FL_RD:  st_next = S_FL_CHK;
            S_FL_CHK:
            begin
                if (!stall)
                begin
                    if (!last_slot)
                        st_next = S_FL_RD;
                    else
                    begin
                        case (fthen_reg)
                            FT_NEW:  st_next = S_GAPCHK;
                            FT_JUMP: st_next = S_SL_RD;
                            default: st_next = S_FIN;
                        endcase
                    end
                end
            end
            S_GAPCHK:
            begin
                if (gap_due)
                    st_next = S_GS_RD;
                else
                    st_next = (cmd_reg.cls == CLS_TICK) ? S_PR_RD : S_SEQCHK;
            end
            S_GS_RD:  st_next = S_GS_CHK;
            S_GS_CHK: st_next = last_slot ? S_GS_END : S_GS_RD;
            S_GS_END: st_next = (cmd_reg.cls == CLS_TICK) ? S_PR_RD : S_SEQCHK;
            S_SEQCHK:
            begin
                if (d_seq[31])
                    st_next = S_ONE;
                else if (d_seq >= 32'(WINDOW))
                    st_next = S_FL_RD;
                else
                    st_next = S_SL_RD;
            end
            S_SL_RD:  st_next = S_SL_CHK;
            S_SL_CHK: st_next = rd_reg.valid ? S_ONE : S_PR_RD;
            S_PR_RD:  st_next = S_PR_CHK;
            S_PR_CHK:
            begin
                if (!stall)
                    st_next = ready ? S_PR_RD : S_FIN;
            end
            S_ONE:    if (!stall) st_next = S_FIN;
            S_FIN:    if (!stall) st_next = S_IDLE;
            default:  st_next = S_IDLE;
        endcase
    end

    // Datapath, memory controls and result handling
    always_comb
    begin
        cmd_next         = cmd_reg;
        sidx_next        = sidx_reg;
        w_valid_next     = w_valid_reg;
        w_epoch_next     = w_epoch_reg;
        w_ne_next        = w_ne_reg;
        w_held_next      = w_held_reg;
        w_gs_next        = w_gs_reg;
        i_next           = i_reg;
        found_next       = found_reg;
        best_d_next      = best_d_reg;
        best_seq_next    = best_seq_reg;
        poured_next      = poured_reg;
        fthen_next       = fthen_reg;
        one_kind_next    = one_kind_reg;
        addr_next        = addr_reg;
        clr_next         = clr_reg;
        cmd_pop          = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = addr_reg;
        wr_en            = 1'b0;
        wr_addr          = addr_reg;
        wr_data          = '0;
        emit             = 1'b0;
        emit_kind        = KIND_DELIV;
        emit_handle      = cmd_reg.handle;
        wb_en            = 1'b0;
        pend_valid_next  = pend_valid_reg;
        pend_kind_next   = pend_kind_reg;
        pend_handle_next = pend_handle_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_kind_next    = out_kind_reg;
        out_handle_next  = out_handle_reg;
        out_last_next    = out_last_reg;

        unique case (st_reg)
            // Sweep the slot memory after reset
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            // Take the next command and load its stream
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    cmd_next     = cmd;
                    sidx_next    = SIW'(cmd.stream_id);
                    w_valid_next = sv_arr[SIW'(cmd.stream_id)];
                    w_epoch_next = ep_arr[SIW'(cmd.stream_id)];
                    w_ne_next    = ne_arr[SIW'(cmd.stream_id)];
                    w_held_next  = hc_arr[SIW'(cmd.stream_id)];
                    w_gs_next    = gs_arr[SIW'(cmd.stream_id)];
                end
            end
            S_DECIDE:
            begin
                i_next        = '0;
                poured_next   = 1'b0;
                one_kind_next = KIND_DELIV;
                fthen_next    = (cmd_reg.cls == CLS_RST) ? FT_RST : FT_NEW;
            end
            S_FL_RD, S_GS_RD:
            begin
                rd_en     = 1'b1;
                rd_addr   = AW'({sidx_reg, i_reg});
                addr_next = AW'({sidx_reg, i_reg});
            end
            // Flush one slot per pass, and finish the walk after the last slot
            S_FL_CHK:
            begin
                if (!stall)
                begin
                    if (rd_reg.valid)
                    begin
                        emit        = 1'b1;
                        emit_kind   = KIND_FLUSH;
                        emit_handle = rd_reg.handle;
                        wr_en       = 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                    if (last_slot)
                    begin
                        w_held_next = '0;
                        w_gs_next   = '0;
                        case (fthen_reg)
                            FT_NEW:
                            begin
                                w_epoch_next = cmd_reg.epoch;
                                w_ne_next    = 32'd1;
                                w_valid_next = 1'b1;
                            end
                            FT_JUMP:
                            begin
                                w_ne_next = cmd_reg.seq;
                            end
                            default:
                            begin
                                w_epoch_next = '0;
                                w_ne_next    = '0;
                                w_valid_next = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_GAPCHK:
            begin
                i_next     = '0;
                found_next = 1'b0;
            end
            // Track the oldest held sequence ahead of the gap
            S_GS_CHK:
            begin
                i_next = i_reg + 1'b1;
                if (rd_reg.valid && !d_slot[31] && (!found_reg || d_slot < best_d_reg))
                begin
                    found_next    = 1'b1;
                    best_d_next   = d_slot;
                    best_seq_next = rd_reg.seq;
                end
            end
            S_GS_END:
            begin
                if (found_reg)
                begin
                    w_ne_next = best_seq_reg;
                    w_gs_next = '0;
                end
            end
            S_SEQCHK:
            begin
                i_next        = '0;
                fthen_next    = FT_JUMP;
                one_kind_next = KIND_DROP;
            end
            S_SL_RD:
            begin
                rd_en     = 1'b1;
                rd_addr   = AW'({sidx_reg, cmd_reg.seq[WW-1:0]});
                addr_next = AW'({sidx_reg, cmd_reg.seq[WW-1:0]});
            end
            // Store the packet unless its slot is taken
            S_SL_CHK:
            begin
                poured_next = 1'b0;
                if (!rd_reg.valid)
                begin
                    wr_en          = 1'b1;
                    wr_data.valid  = 1'b1;
                    wr_data.seq    = cmd_reg.seq;
                    wr_data.handle = cmd_reg.handle;
                    w_held_next    = w_held_reg + 1'b1;
                    if (cmd_reg.seq != w_ne_reg && w_gs_reg == '0)
                        w_gs_next = cmd_reg.now;
                end
            end
            S_PR_RD:
            begin
                rd_en     = 1'b1;
                rd_addr   = AW'({sidx_reg, w_ne_reg[WW-1:0]});
                addr_next = AW'({sidx_reg, w_ne_reg[WW-1:0]});
            end
            // Deliver the expected packet, or close the run
            S_PR_CHK:
            begin
                if (ready)
                begin
                    if (!stall)
                    begin
                        emit        = 1'b1;
                        emit_kind   = KIND_DELIV;
                        emit_handle = rd_reg.handle;
                        wr_en       = 1'b1;
                        if (w_held_reg != '0)
                            w_held_next = w_held_reg - 1'b1;
                        w_ne_next   = w_ne_reg + 32'd1;
                        w_gs_next   = '0;
                        poured_next = 1'b1;
                    end
                end
                else if (poured_reg && w_held_reg != '0 && w_gs_reg == '0)
                begin
                    w_gs_next = cmd_reg.now;
                end
            end
            S_ONE:
            begin
                if (!stall)
                begin
                    emit      = 1'b1;
                    emit_kind = one_kind_reg;
                end
            end
            // Release the final result and store the stream back for packet, tick and reset commands
            S_FIN:
            begin
                if (!stall)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = pend_kind_reg;
                        out_handle_next = pend_handle_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    wb_en = (cmd_reg.cls == CLS_PKT) || (cmd_reg.cls == CLS_TICK) ||
                            (cmd_reg.cls == CLS_RST);
                end
            end
            default:
            begin
            end
        endcase

        // Spill the pending result when a newer one arrives
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = pend_kind_reg;
                out_handle_next = pend_handle_reg;
                out_last_next   = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_kind_next   = emit_kind;
            pend_handle_next = emit_handle;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_handle_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_CLEAR;
            clr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < STREAMS; k++)
            begin
                sv_arr[k] <= 1'b0;
                ep_arr[k] <= '0;
                ne_arr[k] <= '0;
                hc_arr[k] <= '0;
                gs_arr[k] <= '0;
            end
        end
        else
        begin
            st_reg         <= st_next;
            clr_reg        <= clr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (wb_en)
            begin
                sv_arr[sidx_reg] <= w_valid_reg;
                ep_arr[sidx_reg] <= w_epoch_reg;
                ne_arr[sidx_reg] <= w_ne_reg;
                hc_arr[sidx_reg] <= w_held_reg;
                gs_arr[sidx_reg] <= w_gs_reg;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        sidx_reg        <= sidx_next;
        w_valid_reg     <= w_valid_next;
        w_epoch_reg     <= w_epoch_next;
        w_ne_reg        <= w_ne_next;
        w_held_reg      <= w_held_next;
        w_gs_reg        <= w_gs_next;
        i_reg           <= i_next;
        found_reg       <= found_next;
        best_d_reg      <= best_d_next;
        best_seq_reg    <= best_seq_next;
        poured_reg      <= poured_next;
        fthen_reg       <= fthen_next;
        one_kind_reg    <= one_kind_next;
        addr_reg        <= addr_next;
        pend_kind_reg   <= pend_kind_next;
        pend_handle_reg <= pend_handle_next;
        out_kind_reg    <= out_kind_next;
        out_handle_reg  <= out_handle_next;
        out_last_reg    <= out_last_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/sequence_reorder_buffer_unit.sv
// Top level of the sequence reorder buffer: configuration registers,
// front end and back end. Depends on srb_pkg, srb_front and srb_back.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  tuser func; tdata stream_id, epoch, seq, handle, now
//  m_*      out  m_tvalid / m_tready  tuser kind; tdata out_handle; tlast last
//  cfg_*    in   cfg_we               cfg_addr register index, cfg_data value
//
// The sequencer works on one command at a time and takes the next only when it
// returns to idle; deliveries, flushes and gap searches walk the slot memory
// slot by slot, all bound by its single read port.
// Reset: a clearing pass sweeps all STREAMS * WINDOW slots of the slot memory;
// s_tready stays low until it ends. A two-entry command queue decouples input
// from the sequencer; a stalled output holds the sequencer.
module sequence_reorder_buffer_unit #(
    parameter int STREAMS = srb_pkg::STREAMS_DEF,
    parameter int WINDOW  = srb_pkg::WINDOW_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // stream_id[3:0], epoch[35:4], seq[67:36],
                                    // handle[99:68], now[147:100], zero pad
    input  logic [1:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // out_handle
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [27:0]  cfg_data
);
    import srb_pkg::*;

    logic        enable_reg;
    logic [27:0] hold_reg;
    logic [27:0] hold_clamped;
    logic        clear_done;
    logic        cmd_valid;
    logic        cmd_pop;
    cmd_t        cmd;

    // Clamp the hold time into its legal range
    always_comb
    begin
        if (cfg_data < HOLD_MIN)
            hold_clamped = HOLD_MIN;
        else if (cfg_data > HOLD_MAX)
            hold_clamped = HOLD_MAX;
        else
            hold_clamped = cfg_data;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= ENABLE_RESET;
            hold_reg   <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_HOLD:   hold_reg   <= hold_clamped;
                default:    hold_reg   <= hold_reg;
            endcase
        end
    end

    srb_front #(
        .STREAMS (STREAMS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (enable_reg),
        .clear_done (clear_done),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    srb_back #(
        .STREAMS (STREAMS),
        .WINDOW  (WINDOW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .hold_time  (hold_reg),
        .clear_done (clear_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // No input taken while the slot memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !s_tready)
        else $error("input accepted during clearing pass");

    // No result leaves while the slot memory is being cleared
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !m_tvalid)
        else $error("result shown during clearing pass");

    // A command is only taken from a non-empty queue
    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

endmodule
